// ----- sv/rrts_pkg.sv -----
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants of the round-robin tick scheduler
// Field widths, command codes and fixed limits used by the interfaces and
// the scheduler core.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int ID_W      = 4;
    localparam int BURST_W   = 16;
    localparam int WAIT_W    = 16;
    localparam int QUANTUM_W = 8;
    localparam int ID_COUNT  = 2 ** ID_W;

    typedef logic [ID_W-1:0]      pid_t;
    typedef logic [BURST_W-1:0]   burst_t;
    typedef logic [WAIT_W-1:0]    wait_t;
    typedef logic [QUANTUM_W-1:0] quantum_t;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam wait_t    WAIT_MAX      = {WAIT_W{1'b1}};
    localparam quantum_t QUANTUM_RESET = QUANTUM_W'(1);

endpackage

// ----- sv/rrts_in_if.sv -----
// ----------------------------------------------------------------------------
// rrts_in_if: command channel of the round-robin tick scheduler
// Valid/ready channel that carries one arrive or tick beat.
// ----------------------------------------------------------------------------
interface rrts_in_if;
    import rrts_pkg::*;

    logic   valid;
    logic   ready;
    logic   command;
    pid_t   process_id;
    burst_t burst_length;

    modport source (output valid, command, process_id, burst_length, input ready);
    modport sink   (input valid, command, process_id, burst_length, output ready);

endinterface

// ----- sv/rrts_out_if.sv -----
// ----------------------------------------------------------------------------
// rrts_out_if: result channel of the round-robin tick scheduler
// Valid/ready channel that carries one tick result beat.
// ----------------------------------------------------------------------------
interface rrts_out_if;
    import rrts_pkg::*;

    logic  valid;
    logic  ready;
    logic  busy_res;
    pid_t  running_id;
    logic  finished;
    wait_t waited_ticks;

    modport source (output valid, busy_res, running_id, finished, waited_ticks, input ready);
    modport sink   (input valid, busy_res, running_id, finished, waited_ticks, output ready);

endinterface

// ----- sv/round_robin_tick_scheduler.sv -----
// ----------------------------------------------------------------------------
// round_robin_tick_scheduler: round-robin scheduler with a time quantum
// Arrive beats queue a process at the back of the ready FIFO; tick beats run
// the head process for one unit and report what ran.
// ----------------------------------------------------------------------------
//
//   channel       dir   handshake       beat contents
//   ------------  ----  --------------  -----------------------------------
//   item_in       in    valid/ready     command, process_id, burst_length
//   result_out    out   valid/ready     busy_res, running_id, finished,
//                                       waited_ticks (one per tick beat)
//   quantum_we    in    write strobe    quantum_wdata
//
// One beat per cycle is taken into an input register, unless a tick waits there
// on a held result; the scheduling step (queue head, one table entry, parallel
// wait counters) then runs from that register and loads the result register,
// which presents the tick result. Throughput is one beat per clock when unstalled.
// A held result stalls only a tick in the input register; an arrive there drains.
// Reset empties the queue, clears all active flags and sets quantum to 1.
// ----------------------------------------------------------------------------
module round_robin_tick_scheduler #(
    parameter int MAX_PROCESSES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    rrts_in_if.sink             item_in,
    rrts_out_if.source          result_out,
    input  logic                quantum_we,
    input  rrts_pkg::quantum_t  quantum_wdata
);
    import rrts_pkg::*;

    // FIFO geometry follows the process limit; id tables cover only the ids
    // that the 4-bit id field can name.
    localparam int PW      = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CW      = $clog2(MAX_PROCESSES + 1);
    localparam int NUM_IDS = (MAX_PROCESSES < ID_COUNT) ? MAX_PROCESSES : ID_COUNT;
    localparam int IXW     = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;

    localparam logic [PW:0]   DEPTH_W  = (PW+1)'(MAX_PROCESSES);
    localparam logic [CW-1:0] DEPTH_C  = CW'(MAX_PROCESSES);
    localparam logic [ID_W:0] ID_LIMIT = (ID_W+1)'(NUM_IDS);

    typedef logic [PW-1:0]  ptr_t;
    typedef logic [CW-1:0]  cnt_t;
    typedef logic [IXW-1:0] idx_t;

    // ---------------- configuration ----------------
    quantum_t quantum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RESET;
        end
        else if (quantum_we)
        begin
            quantum_reg <= quantum_wdata;
        end
    end

    // ---------------- input register ----------------
    logic   s1_valid_reg;
    logic   s1_cmd_reg;
    pid_t   s1_pid_reg;
    burst_t s1_burst_reg;
    logic   s1_fire;
    logic   out_free;

    // A tick needs the result register free; an arrive never does.
    assign out_free     = !result_out.valid || result_out.ready;
    assign s1_fire      = s1_valid_reg && ((s1_cmd_reg == CMD_ARRIVE) || out_free);
    assign item_in.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_in.ready)
        begin
            s1_valid_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            s1_cmd_reg   <= item_in.command;
            s1_pid_reg   <= item_in.process_id;
            s1_burst_reg <= item_in.burst_length;
        end
    end

    // ---------------- scheduler state ----------------
    idx_t                ready_fifo [MAX_PROCESSES];
    burst_t              remaining_work [NUM_IDS];
    wait_t               wait_counter [NUM_IDS];
    logic [NUM_IDS-1:0]  active_reg;
    ptr_t                head_reg;
    cnt_t                count_reg;
    quantum_t            slice_reg;

    // Tail slot = (head + count) mod depth; count never exceeds depth.
    logic [PW:0] tail_sum;
    ptr_t        tail_ptr;
    logic [PW:0] head_sum;
    ptr_t        head_inc;

    always_comb
    begin
        tail_sum = (PW+1)'(head_reg) + (PW+1)'(count_reg);
        if (tail_sum >= DEPTH_W)
        begin
            tail_sum = tail_sum - DEPTH_W;
        end
        tail_ptr = tail_sum[PW-1:0];

        head_sum = (PW+1)'(head_reg) + (PW+1)'(1);
        if (head_sum >= DEPTH_W)
        begin
            head_sum = '0;
        end
        head_inc = head_sum[PW-1:0];
    end

    // ---------------- arrive decode ----------------
    logic   is_arrive;
    logic   arrive_ok;
    idx_t   arr_idx;
    burst_t arr_burst;

    assign is_arrive = s1_fire && (s1_cmd_reg == CMD_ARRIVE);
    assign arr_idx   = s1_pid_reg[IXW-1:0];
    assign arr_burst = (s1_burst_reg == '0) ? BURST_W'(1) : s1_burst_reg;

    // Drop arrivals for ids beyond the table, ids already queued, or a full queue.
    assign arrive_ok = is_arrive
                    && ((ID_W+1)'(s1_pid_reg) < ID_LIMIT)
                    && !active_reg[arr_idx]
                    && (count_reg < DEPTH_C);

    // ---------------- tick decode ----------------
    logic        is_tick;
    logic        q_empty;
    logic        run_ok;
    idx_t        run_idx;
    burst_t      rem_next;
    logic        done;
    logic [QUANTUM_W:0] slice_sum;
    quantum_t    q_eff;
    logic        rotate;

    assign is_tick   = s1_fire && (s1_cmd_reg == CMD_TICK);
    assign q_empty   = (count_reg == '0);
    assign run_ok    = is_tick && !q_empty;
    assign run_idx   = ready_fifo[head_reg];
    assign rem_next  = remaining_work[run_idx] - BURST_W'(1);
    assign done      = (rem_next == '0);
    assign slice_sum = (QUANTUM_W+1)'(slice_reg) + (QUANTUM_W+1)'(1);
    // Treat a zero quantum as one.
    assign q_eff     = (quantum_reg == '0) ? QUANTUM_W'(1) : quantum_reg;
    assign rotate    = !done && (slice_sum >= (QUANTUM_W+1)'(q_eff));

    // Control state: queue pointers, active flags, slice counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            head_reg   <= '0;
            count_reg  <= '0;
            slice_reg  <= '0;
        end
        else if (arrive_ok)
        begin
            active_reg[arr_idx] <= 1'b1;
            count_reg           <= count_reg + CW'(1);
        end
        else if (run_ok)
        begin
            if (done)
            begin
                // Finished: drop from the head and retire the id.
                active_reg[run_idx] <= 1'b0;
                head_reg            <= head_inc;
                count_reg           <= count_reg - CW'(1);
                slice_reg           <= '0;
            end
            else if (rotate)
            begin
                // Quantum used up: head entry is copied to the tail below.
                head_reg  <= head_inc;
                slice_reg <= '0;
            end
            else
            begin
                slice_reg <= slice_sum[QUANTUM_W-1:0];
            end
        end
    end

    // Tables: written only for ids in use, so they carry no reset.
    always_ff @(posedge clk)
    begin
        if (arrive_ok)
        begin
            ready_fifo[tail_ptr]    <= arr_idx;
            remaining_work[arr_idx] <= arr_burst;
            wait_counter[arr_idx]   <= '0;
        end
        else if (run_ok)
        begin
            remaining_work[run_idx] <= rem_next;
            if (rotate)
            begin
                ready_fifo[tail_ptr] <= run_idx;
            end
            for (int i = 0; i < NUM_IDS; i++)
            begin
                if ((IXW'(i) != run_idx) && active_reg[i] && (wait_counter[i] != WAIT_MAX))
                begin
                    wait_counter[i] <= wait_counter[i] + WAIT_W'(1);
                end
            end
        end
    end

    // ---------------- result register ----------------
    logic  out_valid_reg;
    logic  busy_reg;
    pid_t  run_id_reg;
    logic  finished_reg;
    wait_t waited_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (is_tick)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load a fresh beat on every tick; an empty queue reports all zeros.
    always_ff @(posedge clk)
    begin
        if (is_tick)
        begin
            busy_reg     <= run_ok;
            run_id_reg   <= run_ok ? ID_W'(run_idx) : '0;
            finished_reg <= run_ok && done;
            waited_reg   <= (run_ok && done) ? wait_counter[run_idx] : '0;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.busy_res     = busy_reg;
    assign result_out.running_id   = run_id_reg;
    assign result_out.finished     = finished_reg;
    assign result_out.waited_ticks = waited_reg;

endmodule
